>>> hdl/aarm_pkg.sv
// ---------------------------------------------------------------------------
// Axis-angle rotation matrix package
// Shared widths, CORDIC arctangent table and the packed pipeline type.
// ---------------------------------------------------------------------------
package aarm_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int AXIS_W        = 16;
  localparam int ANGLE_W       = 16;
  localparam int ENTRY_W       = 18;
  localparam int CS_W          = 34;  // x, y headroom over Q30
  localparam int Z_W           = 33;
  localparam logic signed [CS_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [ENTRY_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [ENTRY_W-1:0] OUT_MIN = -18'sd131071 - 18'sd1;

  typedef struct packed {
    logic signed [CS_W-1:0] x;
    logic signed [CS_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } cordic_t;

  function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B; 5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53; 5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001; default: v = 32'h00000000;
    endcase
    return signed'({1'b0, v});
  endfunction

endpackage

>>> hdl/axis_angle_rotation_matrix_core.sv
// ---------------------------------------------------------------------------
// Axis-angle rotation matrix core
// Throughput: one transaction per cycle; one CORDIC iteration per stage, then
// three entry stages. The whole pipeline stalls only when the output is full.
// Reset clears the valid bits only; payload registers are not reset.
// ---------------------------------------------------------------------------
module axis_angle_rotation_matrix_core import aarm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // axis_x, axis_y, axis_z, turn_angle
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata   // m00 m01 m02 m10 m11 m12 m20 m21 m22, zero pad
);

  localparam int NS = CORDIC_STAGES + 5;  // valid stages incl. output

  logic [NS-1:0] vld_r;
  logic          adv;
  cordic_t       cs_r [0:CORDIC_STAGES];
  logic signed [AXIS_W-1:0] ax_r [0:CORDIC_STAGES+1];
  logic signed [AXIS_W-1:0] ay_r [0:CORDIC_STAGES+1];
  logic signed [AXIS_W-1:0] az_r [0:CORDIC_STAGES+1];
  logic signed [CS_W-1:0] c_r, s_r;
  logic [31:0] a_in;
  logic signed [ENTRY_W-1:0] m [0:8];

  // single global advance: output empty or being taken
  assign adv       = !vld_r[NS-1] || out_tready;
  assign in_tready = adv;
  assign out_tvalid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NS-2:0], in_tvalid};
  end

  always_comb begin
    a_in = {in_tdata[63:48], 16'h0000};
    if (a_in[31:30] == 2'b01 || a_in[31:30] == 2'b10) a_in = a_in - 32'h80000000;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r[0].x    <= GAIN_Q30;
      cs_r[0].y    <= '0;
      cs_r[0].z    <= Z_W'(signed'(a_in));
      cs_r[0].flip <= (in_tdata[63:62] == 2'b01) || (in_tdata[63:62] == 2'b10);
      ax_r[0] <= in_tdata[15:0];
      ay_r[0] <= in_tdata[31:16];
      az_r[0] <= in_tdata[47:32];
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        if (!cs_r[i].z[Z_W-1]) begin
          cs_r[i+1].x <= cs_r[i].x - (cs_r[i].y >>> (i % 32));
          cs_r[i+1].y <= cs_r[i].y + (cs_r[i].x >>> (i % 32));
          cs_r[i+1].z <= cs_r[i].z - atan_turn(5'(i % 32));
        end else begin
          cs_r[i+1].x <= cs_r[i].x + (cs_r[i].y >>> (i % 32));
          cs_r[i+1].y <= cs_r[i].y - (cs_r[i].x >>> (i % 32));
          cs_r[i+1].z <= cs_r[i].z + atan_turn(5'(i % 32));
        end
        cs_r[i+1].flip <= cs_r[i].flip;
      end
      for (int i = 0; i <= CORDIC_STAGES; i++) begin
        ax_r[i+1] <= ax_r[i];
        ay_r[i+1] <= ay_r[i];
        az_r[i+1] <= az_r[i];
      end
      c_r <= cs_r[CORDIC_STAGES].flip ? -cs_r[CORDIC_STAGES].x : cs_r[CORDIC_STAGES].x;
      s_r <= cs_r[CORDIC_STAGES].flip ? -cs_r[CORDIC_STAGES].y : cs_r[CORDIC_STAGES].y;
    end
  end

  logic signed [AXIS_W-1:0] ex, ey, ez;
  logic signed [AXIS_W:0]   kx, ky, kz, kzero;
  assign ex = ax_r[CORDIC_STAGES+1];
  assign ey = ay_r[CORDIC_STAGES+1];
  assign ez = az_r[CORDIC_STAGES+1];
  assign kx = (AXIS_W+1)'(ex);
  assign ky = (AXIS_W+1)'(ey);
  assign kz = (AXIS_W+1)'(ez);
  assign kzero = '0;

  aarm_entry u_e00 (.clk, .en({3{adv}}), .c(c_r), .s(s_r), .ai(ex), .aj(ex),
                    .k(kzero), .diag(1'b1), .entry(m[0]));
  aarm_entry u_e01 (.clk, .en({3{adv}}), .c(c_r), .s(s_r), .ai(ex), .aj(ey),
                    .k(-kz), .diag(1'b0), .entry(m[1]));
  aarm_entry u_e02 (.clk, .en({3{adv}}), .c(c_r), .s(s_r), .ai(ex), .aj(ez),
                    .k(ky), .diag(1'b0), .entry(m[2]));
  aarm_entry u_e10 (.clk, .en({3{adv}}), .c(c_r), .s(s_r), .ai(ey), .aj(ex),
                    .k(kz), .diag(1'b0), .entry(m[3]));
  aarm_entry u_e11 (.clk, .en({3{adv}}), .c(c_r), .s(s_r), .ai(ey), .aj(ey),
                    .k(kzero), .diag(1'b1), .entry(m[4]));
  aarm_entry u_e12 (.clk, .en({3{adv}}), .c(c_r), .s(s_r), .ai(ey), .aj(ez),
                    .k(-kx), .diag(1'b0), .entry(m[5]));
  aarm_entry u_e20 (.clk, .en({3{adv}}), .c(c_r), .s(s_r), .ai(ez), .aj(ex),
                    .k(-ky), .diag(1'b0), .entry(m[6]));
  aarm_entry u_e21 (.clk, .en({3{adv}}), .c(c_r), .s(s_r), .ai(ez), .aj(ey),
                    .k(kx), .diag(1'b0), .entry(m[7]));
  aarm_entry u_e22 (.clk, .en({3{adv}}), .c(c_r), .s(s_r), .ai(ez), .aj(ez),
                    .k(kzero), .diag(1'b1), .entry(m[8]));

  assign out_tdata = {6'b0, m[8], m[7], m[6], m[5], m[4], m[3], m[2], m[1], m[0]};

endmodule

>>> hdl/aarm_entry.sv
// ---------------------------------------------------------------------------
// Matrix entry pipeline
// Three stages: products, scaled product, then sum, round and saturate.
// Enables come from the top level so all entries advance together.
// ---------------------------------------------------------------------------
module aarm_entry import aarm_pkg::*; (
  input  logic                       clk,
  input  logic [2:0]                 en,
  input  logic signed [CS_W-1:0]     c,
  input  logic signed [CS_W-1:0]     s,
  input  logic signed [AXIS_W-1:0]   ai,
  input  logic signed [AXIS_W-1:0]   aj,
  input  logic signed [AXIS_W:0]     k,
  input  logic                       diag,
  output logic signed [ENTRY_W-1:0]  entry
);

  logic signed [2*AXIS_W-1:0]  p_r;
  logic signed [CS_W+AXIS_W:0] sk_r, sk2_r;
  logic signed [CS_W:0]        omc_r;
  logic signed [CS_W-1:0]      c_r, c2_r;
  logic                        diag_r, diag2_r;
  logic signed [CS_W+2*AXIS_W:0] q_r;
  logic signed [ENTRY_W-1:0]   entry_r;
  logic signed [CS_W+2*AXIS_W+2:0] acc;
  logic signed [CS_W+2*AXIS_W+2-30:0] r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r    <= ai * aj;
      sk_r   <= s * k;
      omc_r  <= (CS_W+1)'(signed'(35'sd1073741824)) - (CS_W+1)'(c);
      c_r    <= c;
      diag_r <= diag;
    end
    if (en[1]) begin
      q_r     <= (omc_r * p_r) >>> FRAC_BITS;
      sk2_r   <= sk_r;
      c2_r    <= c_r;
      diag2_r <= diag_r;
    end
    if (en[2]) entry_r <= (r > (CS_W+2*AXIS_W+3-30)'(OUT_MAX)) ? OUT_MAX :
                          (r < (CS_W+2*AXIS_W+3-30)'(OUT_MIN)) ? OUT_MIN :
                          ENTRY_W'(r);
  end

  always_comb begin
    acc = (CS_W+2*AXIS_W+3)'(q_r) + (CS_W+2*AXIS_W+3)'(sk2_r)
        + (diag2_r ? ((CS_W+2*AXIS_W+3)'(c2_r) <<< FRAC_BITS) : '0)
        + (CS_W+2*AXIS_W+3)'(signed'(31'sd536870912));
    r = (CS_W+2*AXIS_W+3-30)'(acc >>> 30);
  end

  assign entry = entry_r;

endmodule
